@@ hw/rtl/edmc_pkg.sv @@
// Package for the encoder drive move controller.
// Holds the beat types, register indexes, reset values and fixed constants.
// No dependencies.
`default_nettype none

package edmc_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int FIELD_BITS = 16;
	localparam int SPEED_BITS = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_MODE      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIST_TARGET    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_TARGET    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_WINDOW    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_TURN      = 3'd5;

	localparam logic MODE_STRAIGHT = 1'b0;
	localparam logic MODE_TURN     = 1'b1;

	// register reset values
	localparam logic [8:0]  BASE_SPEED_RST  = 9'd200;
	localparam logic [18:0] TURN_WINDOW_RST = 19'd5139;
	localparam logic [18:0] HALF_TURN_RST   = 19'd403643;

	localparam logic signed [SPEED_BITS-1:0] SLOW_SPEED = 16'sd25;
	localparam logic signed [SPEED_BITS-1:0] SPEED_MAX  = 16'sd32767;
	localparam logic signed [31:0] DEADBAND = 32'sd50;
	localparam logic [1:0] RAMP_TICKS = 2'd3;

	// boost = |drift| / 100 as a reciprocal multiply; any |drift| at or above
	// the limit gives a boost that saturates the speed anyway
	localparam logic [31:0] BOOST_SAT_LIMIT = 32'd3276800;
	localparam int BOOST_IN_BITS = 22;
	localparam logic [22:0] BOOST_RECIP = 23'd5368710;
	localparam int BOOST_SHIFT = 29;

	typedef struct packed {
		logic                  start_req;
		logic [FIELD_BITS-1:0] left_count;
		logic [FIELD_BITS-1:0] right_count;
	} sample_t;

	typedef struct packed {
		logic signed [SPEED_BITS-1:0] right_speed;
		logic signed [SPEED_BITS-1:0] left_speed;
		logic                         done_res;
	} speed_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/encoder_drive_move_controller_unit.sv @@
// Encoder drive move controller, top level.
// Depends on edmc_pkg for beat types, register indexes and constants.
//
//   channel   direction  handshake                payload
//   sample    in         sample_valid/stall       edmc_pkg::sample_t
//   speed     out        speed_valid/stall        edmc_pkg::speed_cmd_t
//   cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One sample beat per cycle sustained while speed_stall is low; a beat passes
// the input register, the state update into stage 2 and the boost multiply
// into the output register before speed_valid rises.
// The move state updates as a beat leaves the input register.
// arst_n clears control state, move state and registers to their reset values.
// speed_stall holds the output register and backs up through the two
// internal stages to sample_stall; cfg_ready is always high.
`default_nettype none

module encoder_drive_move_controller_unit #(
	parameter int COUNT_BITS = edmc_pkg::COUNT_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    sample_valid,
	output logic                                   sample_stall,
	input  wire  edmc_pkg::sample_t                sample,
	output logic                                   speed_valid,
	input  wire                                    speed_stall,
	output edmc_pkg::speed_cmd_t                   speed,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [edmc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire  [edmc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import edmc_pkg::*;

	localparam int CW = COUNT_BITS;
	localparam int PW = (CW < FIELD_BITS) ? CW : FIELD_BITS;
	localparam int SW = ((CW > 32) ? CW : 32) + 2;
	localparam int DW = SW;
	localparam int AW = ((CW + 2 > 24) ? CW + 2 : 24) + 1;

	typedef struct packed {
		logic        start;
		logic        mode;
		logic        ramp;
		logic        turn_neg;
		logic [31:0] total;
		logic [31:0] drift;
		logic [23:0] angle;
	} stage2_t;

	// configuration registers
	logic               move_mode_q;
	logic [8:0]         base_speed_q;
	logic [31:0]        dist_target_q;
	logic signed [19:0] turn_target_q;
	logic [18:0]        turn_window_q;
	logic [18:0]        half_turn_q;

	// move state
	logic [PW-1:0]      prev_l_q;
	logic [PW-1:0]      prev_r_q;
	logic [1:0]         tick_q;
	logic signed [31:0] drift_q;
	logic [31:0]        dist_q;
	logic signed [23:0] angle_q;

	// pipeline
	logic       valid_s1;
	sample_t    sample_s1;
	logic       valid_s2;
	stage2_t    pay_s2;
	logic       speed_valid_q;
	speed_cmd_t speed_q;

	logic adv_out, en2, en1, fire1;

	assign adv_out = !speed_valid_q || !speed_stall;
	assign en2 = !valid_s2 || adv_out;
	assign en1 = !valid_s1 || en2;
	assign fire1 = valid_s1 && en2;
	assign sample_stall = !en1;
	assign cfg_ready = 1'b1;
	assign speed_valid = speed_valid_q;
	assign speed = speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_mode_q <= MODE_STRAIGHT;
			base_speed_q <= BASE_SPEED_RST;
			dist_target_q <= '0;
			turn_target_q <= '0;
			turn_window_q <= TURN_WINDOW_RST;
			half_turn_q <= HALF_TURN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MOVE_MODE:   move_mode_q <= cfg_data[0];
				REG_BASE_SPEED:  base_speed_q <= cfg_data[8:0];
				REG_DIST_TARGET: dist_target_q <= cfg_data[31:0];
				REG_TURN_TARGET: turn_target_q <= cfg_data[19:0];
				REG_TURN_WINDOW: turn_window_q <= cfg_data[18:0];
				REG_HALF_TURN:   half_turn_q <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// ---- stage 1: state update ----
	logic [PW-1:0]        cur_l, cur_r;
	logic [CW-1:0]        dl_fwd, dr_fwd, dl_bwd, dr_bwd;
	logic [CW:0]          turn_sum;
	logic [SW-1:0]        dsum;
	logic [31:0]          dist_new;
	logic signed [DW-1:0] dd;
	logic signed [31:0]   drift_run;
	logic signed [AW-1:0] a_ext, s_ext, a_raw, h_ext, a_wrap;
	logic signed [23:0]   angle_new;
	logic                 ramp;

	always_comb begin
		cur_l = PW'(sample_s1.left_count);
		cur_r = PW'(sample_s1.right_count);
		dl_fwd = CW'(cur_l) - CW'(prev_l_q);
		dr_fwd = CW'(cur_r) - CW'(prev_r_q);
		dl_bwd = CW'(prev_l_q) - CW'(cur_l);
		dr_bwd = CW'(prev_r_q) - CW'(cur_r);
		ramp = tick_q < RAMP_TICKS;

		dsum = SW'(dist_q) + SW'(dl_fwd) + SW'(dr_fwd);
		dist_new = (|dsum[SW-1:32]) ? 32'hFFFF_FFFF : dsum[31:0];

		dd = DW'(drift_q) + DW'($signed({1'b0, dl_fwd})) - DW'($signed({1'b0, dr_fwd}));
		if ((&dd[DW-1:31]) || !(|dd[DW-1:31]))
			drift_run = dd[31:0];
		else
			drift_run = dd[DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;

		if (turn_target_q[19])
			turn_sum = {1'b0, dl_fwd} + {1'b0, dr_bwd};
		else
			turn_sum = {1'b0, dl_bwd} + {1'b0, dr_fwd};
		a_ext = AW'(angle_q);
		s_ext = AW'({1'b0, turn_sum});
		a_raw = turn_target_q[19] ? a_ext - s_ext : a_ext + s_ext;
		h_ext = AW'({1'b0, half_turn_q});
		if (a_raw > h_ext)
			a_wrap = a_raw - (h_ext + h_ext);
		else if (a_raw < -h_ext)
			a_wrap = a_raw + (h_ext + h_ext);
		else
			a_wrap = a_raw;
		if ((&a_wrap[AW-1:23]) || !(|a_wrap[AW-1:23]))
			angle_new = a_wrap[23:0];
		else
			angle_new = a_wrap[AW-1] ? 24'sh80_0000 : 24'sh7F_FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			tick_q <= '0;
			drift_q <= '0;
			dist_q <= '0;
			angle_q <= '0;
		end else if (fire1) begin
			prev_l_q <= cur_l;
			prev_r_q <= cur_r;
			if (sample_s1.start_req) begin
				tick_q <= '0;
				drift_q <= '0;
				dist_q <= '0;
				angle_q <= '0;
			end else if (move_mode_q == MODE_STRAIGHT) begin
				dist_q <= dist_new;
				if (ramp) begin
					tick_q <= tick_q + 2'd1;
					drift_q <= '0;
				end else begin
					drift_q <= drift_run;
				end
			end else begin
				angle_q <= angle_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			speed_valid_q <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= sample_valid;
			if (en2)
				valid_s2 <= valid_s1;
			if (adv_out)
				speed_valid_q <= valid_s2;
		end
	end

	// ---- stage 2: boost and done ----
	speed_cmd_t         speed_next;
	logic signed [31:0] d2;
	logic [31:0]        mag;
	logic               big;
	logic [44:0]        prod;
	logic [16:0]        boosted;
	logic signed [15:0] run_speed, base_s;
	logic signed [24:0] a25, win_hi, win_lo;

	always_comb begin
		d2 = $signed(pay_s2.drift);
		mag = d2[31] ? 32'(-d2) : 32'(d2);
		big = mag >= BOOST_SAT_LIMIT;
		prod = mag[BOOST_IN_BITS-1:0] * BOOST_RECIP;
		boosted = {1'b0, prod[BOOST_SHIFT+15:BOOST_SHIFT]} + 17'(base_speed_q);
		if (big || boosted > 17'(SPEED_MAX))
			run_speed = SPEED_MAX;
		else
			run_speed = boosted[15:0];
		base_s = 16'(base_speed_q);

		a25 = 25'($signed(pay_s2.angle));
		win_hi = 25'(turn_target_q) + 25'({1'b0, turn_window_q});
		win_lo = 25'(turn_target_q) - 25'({1'b0, turn_window_q});

		speed_next = '0;
		if (pay_s2.start) begin
			speed_next = '0;
		end else if (pay_s2.mode == MODE_STRAIGHT) begin
			speed_next.done_res = pay_s2.total > dist_target_q;
			if (pay_s2.ramp) begin
				speed_next.right_speed = SLOW_SPEED;
				speed_next.left_speed = SLOW_SPEED;
			end else begin
				speed_next.right_speed = (d2 > DEADBAND) ? run_speed : base_s;
				speed_next.left_speed = (d2 < -DEADBAND) ? run_speed : base_s;
			end
		end else begin
			speed_next.done_res = (a25 < win_hi) && (a25 > win_lo);
			speed_next.right_speed = pay_s2.turn_neg ? -SLOW_SPEED : SLOW_SPEED;
			speed_next.left_speed = pay_s2.turn_neg ? SLOW_SPEED : -SLOW_SPEED;
		end
	end

	always_ff @(posedge clk) begin
		if (en1)
			sample_s1 <= sample;
		if (en2) begin
			pay_s2.start <= sample_s1.start_req;
			pay_s2.mode <= move_mode_q;
			pay_s2.ramp <= ramp;
			pay_s2.turn_neg <= turn_target_q[19];
			pay_s2.total <= dist_new;
			pay_s2.drift <= drift_run;
			pay_s2.angle <= angle_new;
		end
		if (adv_out)
			speed_q <= speed_next;
	end

`ifndef SYNTHESIS
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1)
		else $error("sample_stall without a beat in the input register");

	a_ramp_drift_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != RAMP_TICKS) |-> (drift_q == '0))
		else $error("drift nonzero during ramp ticks");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && pay_s2.start && adv_out) |=> (speed_valid_q && speed_q == '0))
		else $error("start beat result not zero");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && !valid_s2) |=> !speed_valid_q)
		else $error("output beat appeared with empty stage 2");
`endif

endmodule

`default_nettype wire
